[design/svwap_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svwap_pkg
// Shared types, codes and constants of the wrap-aware wheel-mode positioner.
// ----------------------------------------------------------------------------
package svwap_pkg;

    // history of coarse samples
    localparam int HISTORY_DEPTH = 4;

    // item commands
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // move phases
    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_COARSE = 2'd1;
    localparam logic [1:0] PHASE_FINE   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_SPEED = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED     = 2'd1;
    localparam logic [1:0] CFG_MIN_SPEED     = 2'd2;
    localparam logic [1:0] CFG_DEAD_BAND     = 2'd3;

    // configuration reset values
    localparam logic [9:0] DEFAULT_SPEED_RST = 10'd512;
    localparam logic [9:0] MAX_SPEED_RST     = 10'd1023;
    localparam logic [9:0] MIN_SPEED_RST     = 10'd40;
    localparam logic [5:0] DEAD_BAND_RST     = 6'd3;

    // position limits and thresholds
    localparam logic [9:0]        POS_TOP      = 10'h3FF;
    localparam logic [9:0]        POS_BOTTOM   = 10'h000;
    localparam logic [9:0]        NEAR_LIMIT   = 10'h040;
    localparam logic signed [10:0] STEP_LIMIT  = 11'sd15;
    localparam logic [9:0]        STALL_SPAN   = 10'd10;
    localparam logic [31:0]       STALL_MS     = 32'd500;
    localparam logic [31:0]       FINE_MS      = 32'd2000;

    // fine speed percentage: 20 + 80*err/30, full above the table
    localparam logic [9:0] PCT_TABLE_LEN = 10'd30;
    localparam logic [6:0] PCT_FULL      = 7'd100;
    localparam logic [6:0] PCT_TABLE [32] = '{
        7'd20, 7'd22, 7'd25, 7'd28, 7'd30, 7'd33, 7'd36, 7'd38,
        7'd41, 7'd44, 7'd46, 7'd49, 7'd52, 7'd54, 7'd57, 7'd60,
        7'd62, 7'd65, 7'd68, 7'd70, 7'd73, 7'd76, 7'd78, 7'd81,
        7'd84, 7'd86, 7'd89, 7'd92, 7'd94, 7'd97, 7'd100, 7'd100
    };

    // divide by 100 through reciprocal multiply, exact for products below 2^17
    localparam logic [34:0] DIV100_MUL = 35'd167773;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic emit;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // absolute difference of two positions
    function automatic logic [9:0] pos_dist(input logic [9:0] a, input logic [9:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // fine speed percentage for a given error
    function automatic logic [6:0] pct_of(input logic [9:0] err);
        return (err >= PCT_TABLE_LEN) ? PCT_FULL : PCT_TABLE[err[4:0]];
    endfunction

endpackage
`default_nettype wire

[design/svwap_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svwap_ctrl
// Sequencer: takes one word, then steps the datapath through evaluate,
// divide and result load.
// ----------------------------------------------------------------------------
module svwap_ctrl
    import svwap_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EVAL;
            end
            ST_EVAL: n_state = ST_MUL;
            ST_MUL:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd.load = i_in_valid && (r_state == ST_IDLE);
    assign o_cmd.eval = (r_state == ST_EVAL);
    assign o_cmd.mul  = (r_state == ST_MUL);
    assign o_cmd.emit = (r_state == ST_EMIT) && i_status.out_free;

endmodule
`default_nettype wire

[design/svwap_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svwap_dp
// Datapath: configuration registers, move state, coarse sample history,
// fine speed scaling and the result register.
// ----------------------------------------------------------------------------
module svwap_dp
    import svwap_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctrl_cmd   i_cmd,
    output t_dp_status       o_status,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    // input word
    input  wire logic [1:0]  i_item_cmd,
    input  wire logic [9:0]  i_target_position,
    input  wire logic [7:0]  i_speed_setting,
    input  wire logic        i_direction_negative,
    input  wire logic [9:0]  i_position,
    input  wire logic [31:0] i_time_ms,
    // result word
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_speed_valid,
    output logic [10:0]      o_speed_command,
    output logic             o_wheel_mode,
    output logic [1:0]       o_phase,
    output logic [1:0]       o_wait_state,
    output logic             o_finished,
    output logic             o_stuck,
    output logic             o_refused,
    output logic             o_restore_valid,
    output logic [9:0]       o_restore_position
);

    // configuration
    logic [9:0]  r_default_speed, r_max_speed, r_min_speed;
    logic [5:0]  r_dead_band;

    // latched input word
    logic [1:0]  r_cmd;
    logic [9:0]  r_tgt;
    logic [7:0]  r_spd;
    logic        r_dir;
    logic [9:0]  r_pos;
    logic [31:0] r_time;

    // move state
    logic        r_stuck, n_stuck;
    logic [1:0]  r_phase, n_phase;
    logic        r_wait_low, n_wait_low;
    logic        r_wait_high, n_wait_high;
    logic [9:0]  r_recent [HISTORY_DEPTH];
    logic [9:0]  n_recent [HISTORY_DEPTH];
    logic [2:0]  r_seen, n_seen;
    logic [9:0]  r_goal, n_goal;
    logic [9:0]  r_base, n_base;
    logic [9:0]  r_start_pos, n_start_pos;
    logic [31:0] r_start_time, n_start_time;
    logic [31:0] r_fine_time, n_fine_time;

    // staged result
    logic        r_res_sv, n_res_sv;
    logic [10:0] r_res_sc, n_res_sc;
    logic        r_res_fin, n_res_fin;
    logic        r_res_ref, n_res_ref;
    logic        r_res_rv, n_res_rv;
    logic [9:0]  r_res_rp, n_res_rp;
    logic        r_fine_spd, n_fine_spd;
    logic        r_fdir;
    logic [16:0] r_prod;
    logic [9:0]  r_quot;

    // output register
    logic        r_out_valid;
    logic        r_o_sv, r_o_wheel, r_o_fin, r_o_stuck, r_o_ref, r_o_rv;
    logic [10:0] r_o_sc;
    logic [1:0]  r_o_phase, r_o_wait;
    logic [9:0]  r_o_rp;

    // history flags
    logic [9:0]        newer [HISTORY_DEPTH];
    logic signed [10:0] d_dn [HISTORY_DEPTH];
    logic signed [10:0] d_up [HISTORY_DEPTH];
    logic all_hi, all_lo, all_p, desc, asc, leave_hi, leave_lo;

    // shared evaluation terms
    logic [9:0]  m_raw, start_mag, goal_eff, base_eff, err, fine_mag;
    logic [6:0]  pct;
    logic [16:0] prod;
    logic [34:0] qfull;
    logic        fine_call, fine_end, end_call, restore, timed, stall, seen_full;

    // start speed clamp
    always_comb begin
        m_raw = {r_spd, 2'b00};
        if (m_raw == 10'd0) begin
            start_mag = r_default_speed;
        end else if (m_raw > r_max_speed) begin
            start_mag = r_max_speed;
        end else if (m_raw < r_min_speed) begin
            start_mag = r_min_speed;
        end else begin
            start_mag = m_raw;
        end
    end

    // dead zone and step pattern of the sample history
    always_comb begin
        all_hi = 1'b1;
        all_lo = 1'b1;
        all_p  = 1'b1;
        desc   = 1'b1;
        asc    = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            newer[i] = (i == 0) ? r_pos : r_recent[(i == 0) ? 0 : i - 1];
            d_dn[i]  = $signed({1'b0, r_recent[i]}) - $signed({1'b0, newer[i]});
            d_up[i]  = $signed({1'b0, newer[i]}) - $signed({1'b0, r_recent[i]});
            if (r_recent[i] != POS_TOP)    all_hi = 1'b0;
            if (r_recent[i] != POS_BOTTOM) all_lo = 1'b0;
            if (r_recent[i] != r_pos)      all_p  = 1'b0;
            if (d_dn[i] <= 11'sd0 || d_dn[i] >= STEP_LIMIT) desc = 1'b0;
            if (d_up[i] <= 11'sd0 || d_up[i] >= STEP_LIMIT) asc  = 1'b0;
        end
        leave_hi = (r_pos != POS_TOP) && all_hi;
        leave_lo = (r_pos != POS_BOTTOM) && all_lo;
    end

    // per-item decision
    always_comb begin
        n_stuck      = r_stuck;
        n_phase      = r_phase;
        n_wait_low   = r_wait_low;
        n_wait_high  = r_wait_high;
        n_recent     = r_recent;
        n_seen       = r_seen;
        n_goal       = r_goal;
        n_base       = r_base;
        n_start_pos  = r_start_pos;
        n_start_time = r_start_time;
        n_fine_time  = r_fine_time;
        n_res_sv     = 1'b0;
        n_res_sc     = 11'd0;
        n_res_fin    = 1'b0;
        n_res_ref    = 1'b0;
        n_res_rv     = 1'b0;
        n_res_rp     = 10'd0;
        fine_call    = 1'b0;
        end_call     = 1'b0;
        restore      = 1'b0;
        timed        = 1'b0;
        stall        = 1'b0;
        seen_full    = r_seen[2];

        case (r_cmd)
            CMD_START: begin
                if (r_stuck) begin
                    n_res_ref = 1'b1;
                end else begin
                    n_goal       = r_tgt;
                    n_base       = start_mag;
                    n_start_pos  = r_pos;
                    n_start_time = r_time;
                    n_seen       = 3'd0;
                    for (int i = 0; i < HISTORY_DEPTH; i++) n_recent[i] = 10'd0;
                    n_wait_low   = 1'b0;
                    n_wait_high  = 1'b0;
                    n_phase      = PHASE_COARSE;
                    n_res_sv     = 1'b1;
                    n_res_sc     = {r_dir, start_mag};
                    if (!(r_pos == POS_TOP || r_pos == POS_BOTTOM ||
                          pos_dist(r_tgt, r_pos) > NEAR_LIMIT)) begin
                        n_phase     = PHASE_FINE;
                        n_fine_time = r_time;
                        fine_call   = 1'b1;
                    end
                end
            end
            CMD_SAMPLE: begin
                if (r_phase == PHASE_COARSE) begin
                    // dead zone tracking and stall check once history is full
                    if (seen_full) begin
                        if (r_wait_high && (leave_hi || desc)) begin
                            n_wait_high = 1'b0;
                        end else if (leave_hi) begin
                            n_wait_low = 1'b1;
                        end else if (r_wait_low && (leave_lo || asc)) begin
                            n_wait_low = 1'b0;
                        end else if (leave_lo) begin
                            n_wait_high = 1'b1;
                        end else if (r_pos != POS_BOTTOM && r_pos != POS_TOP &&
                                     !r_wait_low && !r_wait_high && all_p &&
                                     (r_time - r_start_time) > STALL_MS &&
                                     pos_dist(r_start_pos, r_pos) < STALL_SPAN) begin
                            stall = 1'b1;
                        end
                    end
                    if (stall) begin
                        n_stuck  = 1'b1;
                        end_call = 1'b1;
                        restore  = 1'b1;
                    end else begin
                        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                            n_recent[i] = r_recent[i - 1];
                        end
                        n_recent[0] = r_pos;
                        n_seen = seen_full ? r_seen : 3'(r_seen + 3'd1);
                        if (!(r_pos == POS_TOP || r_pos == POS_BOTTOM || n_wait_low ||
                              n_wait_high || pos_dist(r_goal, r_pos) > NEAR_LIMIT)) begin
                            n_phase     = PHASE_FINE;
                            n_fine_time = r_time;
                            fine_call   = 1'b1;
                        end
                    end
                end else if (r_phase == PHASE_FINE) begin
                    fine_call = 1'b1;
                    timed     = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_stuck = 1'b0;
            end
            default: begin
            end
        endcase

        // fine approach: end or scaled speed
        goal_eff = (r_cmd == CMD_START) ? r_tgt : r_goal;
        base_eff = (r_cmd == CMD_START) ? start_mag : r_base;
        err      = pos_dist(goal_eff, r_pos);
        pct      = pct_of(err);
        prod     = 17'(base_eff) * 17'(pct);
        fine_end = (err <= {4'd0, r_dead_band}) ||
                   (timed && ((r_time - r_fine_time) >= FINE_MS));
        if (fine_call && fine_end) end_call = 1'b1;
        n_fine_spd = fine_call && !fine_end;
        if (n_fine_spd) n_res_sv = 1'b1;

        // end of move
        if (end_call) begin
            n_phase     = PHASE_IDLE;
            n_wait_low  = 1'b0;
            n_wait_high = 1'b0;
            n_res_sv    = 1'b1;
            n_res_sc    = {1'b0, r_max_speed};
            n_res_fin   = 1'b1;
            if (restore) begin
                n_res_rv = 1'b1;
                n_res_rp = r_start_pos;
            end
        end
    end

    // divide by 100 and floor at minimum speed
    assign qfull    = 35'(r_prod) * DIV100_MUL;
    assign fine_mag = (r_quot < r_min_speed) ? r_min_speed : r_quot;

    // configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_speed <= DEFAULT_SPEED_RST;
            r_max_speed     <= MAX_SPEED_RST;
            r_min_speed     <= MIN_SPEED_RST;
            r_dead_band     <= DEAD_BAND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEFAULT_SPEED: r_default_speed <= i_cfg_data;
                CFG_MAX_SPEED:     r_max_speed     <= i_cfg_data;
                CFG_MIN_SPEED:     r_min_speed     <= i_cfg_data;
                CFG_DEAD_BAND:     r_dead_band     <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // input word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_item_cmd;
            r_tgt  <= i_target_position;
            r_spd  <= i_speed_setting;
            r_dir  <= i_direction_negative;
            r_pos  <= i_position;
            r_time <= i_time_ms;
        end
    end

    // move state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stuck      <= 1'b0;
            r_phase      <= PHASE_IDLE;
            r_wait_low   <= 1'b0;
            r_wait_high  <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) r_recent[i] <= 10'd0;
            r_seen       <= 3'd0;
            r_goal       <= 10'd0;
            r_base       <= 10'd0;
            r_start_pos  <= 10'd0;
            r_start_time <= 32'd0;
            r_fine_time  <= 32'd0;
        end else if (i_cmd.eval) begin
            r_stuck      <= n_stuck;
            r_phase      <= n_phase;
            r_wait_low   <= n_wait_low;
            r_wait_high  <= n_wait_high;
            r_recent     <= n_recent;
            r_seen       <= n_seen;
            r_goal       <= n_goal;
            r_base       <= n_base;
            r_start_pos  <= n_start_pos;
            r_start_time <= n_start_time;
            r_fine_time  <= n_fine_time;
        end
    end

    // staged result and fine speed pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_res_sv   <= n_res_sv;
            r_res_sc   <= n_res_sc;
            r_res_fin  <= n_res_fin;
            r_res_ref  <= n_res_ref;
            r_res_rv   <= n_res_rv;
            r_res_rp   <= n_res_rp;
            r_fine_spd <= n_fine_spd;
            r_fdir     <= !(goal_eff > r_pos);
            r_prod     <= prod;
        end
        if (i_cmd.mul) begin
            r_quot <= qfull[33:24];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_sv    <= r_res_sv;
            r_o_sc    <= r_fine_spd ? {r_fdir, fine_mag} : r_res_sc;
            r_o_wheel <= (r_phase != PHASE_IDLE);
            r_o_phase <= r_phase;
            r_o_wait  <= {r_wait_high, r_wait_low};
            r_o_fin   <= r_res_fin;
            r_o_stuck <= r_stuck;
            r_o_ref   <= r_res_ref;
            r_o_rv    <= r_res_rv;
            r_o_rp    <= r_res_rp;
        end
    end

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_speed_valid       = r_o_sv;
    assign o_speed_command     = r_o_sc;
    assign o_wheel_mode        = r_o_wheel;
    assign o_phase             = r_o_phase;
    assign o_wait_state        = r_o_wait;
    assign o_finished          = r_o_fin;
    assign o_stuck             = r_o_stuck;
    assign o_refused           = r_o_ref;
    assign o_restore_valid     = r_o_rv;
    assign o_restore_position  = r_o_rp;

endmodule
`default_nettype wire

[design/servo_wrap_aware_positioner.sv]
`default_nettype none
// After an input word is taken, the result word is formed by evaluate,
// divide by 100 and load of the result register, in that order.
// The sequencer takes a new word only from idle, after the last word is
// through, and waits in its last step while the result register is full.
// Reset (synchronous, active low) clears the move state, the stuck flag and
// the result valid flag, and loads the configuration registers with defaults.
// ----------------------------------------------------------------------------
// servo_wrap_aware_positioner
// Wheel-mode servo positioner with dead zone tracking, stall detection and a
// scaled fine approach; sequencer plus datapath.
// ----------------------------------------------------------------------------
module servo_wrap_aware_positioner
    import svwap_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [9:0]  i_target_position,
    input  wire logic [7:0]  i_speed_setting,
    input  wire logic        i_direction_negative,
    input  wire logic [9:0]  i_position,
    input  wire logic [31:0] i_time_ms,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_speed_valid,
    output logic [10:0]      o_speed_command,
    output logic             o_wheel_mode,
    output logic [1:0]       o_phase,
    output logic [1:0]       o_wait_state,
    output logic             o_finished,
    output logic             o_stuck,
    output logic             o_refused,
    output logic             o_restore_valid,
    output logic [9:0]       o_restore_position
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // sequencer
    svwap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    // datapath
    svwap_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (ctrl_cmd),
        .o_status             (dp_status),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_item_cmd           (i_cmd),
        .i_target_position    (i_target_position),
        .i_speed_setting      (i_speed_setting),
        .i_direction_negative (i_direction_negative),
        .i_position           (i_position),
        .i_time_ms            (i_time_ms),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_speed_valid        (o_speed_valid),
        .o_speed_command      (o_speed_command),
        .o_wheel_mode         (o_wheel_mode),
        .o_phase              (o_phase),
        .o_wait_state         (o_wait_state),
        .o_finished           (o_finished),
        .o_stuck              (o_stuck),
        .o_refused            (o_refused),
        .o_restore_valid      (o_restore_valid),
        .o_restore_position   (o_restore_position)
    );

endmodule
`default_nettype wire

[verif/tb_servo_wrap_aware_positioner.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_wrap_aware_positioner
// Self-checking bench for the wheel-mode positioner. A driver feeds command
// words from a queue, and an in-bench model of the move logic predicts each
// reply word. A monitor compares the replies field by field. Stimulus is a
// short directed sequence, then random moves that sweep through the dead zone,
// stall, time out and settle, under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_servo_wrap_aware_positioner;
    import svwap_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RING_STEPS      = 1100;   // one wheel turn incl. dead zone
    localparam int ZONE_SPLIT      = 38;     // dead zone reads top, then bottom
    localparam int RANDOM_QUOTA    = 265;
    localparam int MAX_REPORTS     = 100;

    // one command word
    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  target;
        logic [7:0]  speed;
        logic        dir_neg;
        logic [9:0]  pos;
        logic [31:0] ms;
    } t_servo_word;

    // one reply word
    typedef struct packed {
        logic        speed_valid;
        logic [10:0] speed_command;
        logic        wheel_mode;
        logic [1:0]  phase;
        logic [1:0]  wait_state;
        logic        finished;
        logic        stuck;
        logic        refused;
        logic        restore_valid;
        logic [9:0]  restore_position;
    } t_motion_reply;

    // clock, reset and driven inputs
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_DEFAULT_SPEED;
    logic [9:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    t_servo_word cur_word = '0;
    logic        out_ready = 1'b0;

    // block outputs
    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic        speed_valid;
    logic [10:0] speed_command;
    logic        wheel_mode;
    logic [1:0]  phase;
    logic [1:0]  wait_state;
    logic        finished;
    logic        stuck;
    logic        refused;
    logic        restore_valid;
    logic [9:0]  restore_position;

    // bench bookkeeping
    t_servo_word   pending_words[$];
    t_motion_reply expected_replies[$];
    logic          in_fire = 1'b0;
    int            idle_cycles = 0;
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    // register shadows
    logic [9:0] cfg_default = DEFAULT_SPEED_RST;
    logic [9:0] cfg_max     = MAX_SPEED_RST;
    logic [9:0] cfg_min     = MIN_SPEED_RST;
    logic [5:0] cfg_band    = DEAD_BAND_RST;

    // model state of the move
    logic        stuck_q = 1'b0;
    logic [1:0]  phase_q = PHASE_IDLE;
    logic        wait_lo = 1'b0;
    logic        wait_hi = 1'b0;
    logic [9:0]  hist[HISTORY_DEPTH] = '{default: '0};
    int          seen_cnt = 0;
    logic [9:0]  goal_q = '0;
    logic [9:0]  base_spd = '0;
    logic [9:0]  start_pos = '0;
    logic [31:0] start_ms = '0;
    logic [31:0] fine_ms = '0;

    servo_wrap_aware_positioner u_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_cmd                (cur_word.cmd),
        .i_target_position    (cur_word.target),
        .i_speed_setting      (cur_word.speed),
        .i_direction_negative (cur_word.dir_neg),
        .i_position           (cur_word.pos),
        .i_time_ms            (cur_word.ms),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_speed_valid        (speed_valid),
        .o_speed_command      (speed_command),
        .o_wheel_mode         (wheel_mode),
        .o_phase              (phase),
        .o_wait_state         (wait_state),
        .o_finished           (finished),
        .o_stuck              (stuck),
        .o_refused            (refused),
        .o_restore_valid      (restore_valid),
        .o_restore_position   (restore_position)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // move model
    // ------------------------------------------------------------------------

    // distance between two positions
    function automatic int pos_gap(input logic [9:0] a, input logic [9:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    // coarse approach still running at this position
    function automatic bit still_coarse(input logic [9:0] p);
        return p == POS_TOP || p == POS_BOTTOM || wait_lo || wait_hi ||
               pos_gap(goal_q, p) > int'(NEAR_LIMIT);
    endfunction

    // whole history holds one value
    function automatic bit history_all(input logic [9:0] v);
        foreach (hist[i])
            if (hist[i] != v) return 1'b0;
        return 1'b1;
    endfunction

    // every step of the last samples small and in one direction
    function automatic bit creeping(input bit down, input logic [9:0] p);
        int r[HISTORY_DEPTH + 1];
        int d;
        r[0] = int'(p);
        foreach (hist[i]) r[i + 1] = int'(hist[i]);
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            d = down ? r[i + 1] - r[i] : r[i] - r[i + 1];
            if (d <= 0 || d >= int'(STEP_LIMIT)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // end of move, full speed sent as the last command
    function automatic void close_move(input bit restore, inout t_motion_reply r);
        phase_q = PHASE_IDLE;
        wait_lo = 1'b0;
        wait_hi = 1'b0;
        r.speed_valid   = 1'b1;
        r.speed_command = {1'b0, cfg_max};
        r.finished      = 1'b1;
        if (restore) begin
            r.restore_valid    = 1'b1;
            r.restore_position = start_pos;
        end
    endfunction

    // fine approach: speed scaled to the error
    function automatic void fine_update(input logic [9:0] p, input logic [31:0] t,
                                        inout t_motion_reply r);
        int unsigned err, pct, mag;
        logic [31:0] run_ms;
        err    = pos_gap(goal_q, p);
        run_ms = t - fine_ms;
        if (err <= cfg_band || run_ms >= FINE_MS) begin
            close_move(1'b0, r);
        end else begin
            // 20 % plus 80 % of err/30, capped at full
            pct = 20 + (80 * err) / 30;
            if (pct > 100) pct = 100;
            mag = (base_spd * pct) / 100;
            if (mag < cfg_min) mag = cfg_min;
            r.speed_valid   = 1'b1;
            r.speed_command = {goal_q <= p, mag[9:0]};
        end
    endfunction

    function automatic void begin_fine(input logic [9:0] p, input logic [31:0] t,
                                       inout t_motion_reply r);
        phase_q = PHASE_FINE;
        fine_ms = t;
        fine_update(p, t, r);
    endfunction

    // reply to one command word, advancing the model state
    function automatic t_motion_reply predict_motion(input t_servo_word w);
        t_motion_reply r;
        int unsigned   mag;
        bit            leave_hi, leave_lo, stalled;
        logic [31:0]   run_ms;
        r       = '0;
        stalled = 1'b0;
        case (w.cmd)
            CMD_START: begin
                if (stuck_q) begin
                    r.refused = 1'b1;
                end else begin
                    mag = w.speed * 4;
                    if (mag == 0) mag = cfg_default;
                    else if (mag > cfg_max) mag = cfg_max;
                    else if (mag < cfg_min) mag = cfg_min;
                    goal_q    = w.target;
                    base_spd  = mag[9:0];
                    start_pos = w.pos;
                    start_ms  = w.ms;
                    seen_cnt  = 0;
                    hist      = '{default: '0};
                    wait_lo   = 1'b0;
                    wait_hi   = 1'b0;
                    phase_q   = PHASE_COARSE;
                    r.speed_valid   = 1'b1;
                    r.speed_command = {w.dir_neg, base_spd};
                    if (!still_coarse(w.pos)) begin_fine(w.pos, w.ms, r);
                end
            end
            CMD_SAMPLE: begin
                if (phase_q == PHASE_COARSE) begin
                    // dead zone tracking and stall check once history is full
                    if (seen_cnt >= HISTORY_DEPTH) begin
                        leave_hi = w.pos != POS_TOP && history_all(POS_TOP);
                        leave_lo = w.pos != POS_BOTTOM && history_all(POS_BOTTOM);
                        run_ms   = w.ms - start_ms;
                        if (wait_hi && (leave_hi || creeping(1'b1, w.pos))) begin
                            wait_hi = 1'b0;
                        end else if (leave_hi) begin
                            wait_lo = 1'b1;
                        end else if (wait_lo && (leave_lo || creeping(1'b0, w.pos))) begin
                            wait_lo = 1'b0;
                        end else if (leave_lo) begin
                            wait_hi = 1'b1;
                        end else if (w.pos != POS_BOTTOM && w.pos != POS_TOP &&
                                     !wait_lo && !wait_hi && history_all(w.pos) &&
                                     run_ms > STALL_MS &&
                                     pos_gap(start_pos, w.pos) < int'(STALL_SPAN)) begin
                            stuck_q = 1'b1;
                            close_move(1'b1, r);
                            stalled = 1'b1;
                        end
                    end
                    if (!stalled) begin
                        for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist[i] = hist[i - 1];
                        hist[0] = w.pos;
                        if (seen_cnt < HISTORY_DEPTH) seen_cnt++;
                        if (!still_coarse(w.pos)) begin_fine(w.pos, w.ms, r);
                    end
                end else if (phase_q == PHASE_FINE) begin
                    fine_update(w.pos, w.ms, r);
                end
            end
            CMD_CLEAR: stuck_q = 1'b0;
            default: ;
        endcase
        r.wheel_mode = phase_q != PHASE_IDLE;
        r.phase      = phase_q;
        r.wait_state = {wait_hi, wait_lo};
        r.stuck      = stuck_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void push_word(input logic [1:0] cmd, input logic [9:0] tgt,
                                      input logic [7:0] spd, input logic dn,
                                      input logic [9:0] p, input logic [31:0] t);
        t_servo_word w;
        w = '{cmd: cmd, target: tgt, speed: spd, dir_neg: dn, pos: p, ms: t};
        pending_words.push_back(w);
    endfunction

    // one move: start word, then samples of a turning or jammed wheel
    function automatic int queue_move();
        logic [9:0]  tgt, p;
        logic [7:0]  spd;
        logic [31:0] t;
        bit          down, jam;
        int          angle, rem, n, step, made;
        tgt   = 10'($urandom_range(0, 1023));
        spd   = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        down  = 1'($urandom_range(0, 1));
        angle = $urandom_range(0, 1023);
        t     = $urandom;
        jam   = $urandom_range(0, 9) < 2;
        push_word(CMD_START, tgt, spd, down, 10'(angle), t);
        made = 1;
        // a jammed wheel sits just off its start position
        if (jam) angle = angle + $urandom_range(0, 8) > 1022 ? 1022 :
                         angle + $urandom_range(0, 8);
        if (angle < 1) angle = 1;
        n = $urandom_range(6, 70);
        for (int k = 0; k < n; k++) begin
            if (jam) begin
                t += $urandom_range(30, 200);
                p = 10'(angle);
            end else begin
                t += ($urandom_range(0, 39) == 0) ? $urandom_range(1500, 2600)
                                                 : $urandom_range(1, 30);
                rem = down ? (angle - tgt + RING_STEPS) % RING_STEPS
                           : (tgt - angle + RING_STEPS) % RING_STEPS;
                if (rem == 0 && $urandom_range(0, 2) == 0) break;
                if (rem < 64) step = $urandom_range(0, rem < 3 ? rem : 3);
                else step = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 14);
                angle = down ? (angle - step + RING_STEPS) % RING_STEPS
                             : (angle + step) % RING_STEPS;
                // inside the dead zone the pot reads top first, then bottom
                if (angle <= 1023) p = 10'(angle);
                else p = (angle - 1024 < ZONE_SPLIT) ? POS_TOP : POS_BOTTOM;
                if ($urandom_range(0, 29) == 0) p = 10'($urandom_range(0, 1023));
            end
            push_word(CMD_SAMPLE, 10'($urandom), 8'($urandom), 1'($urandom), p, t);
            made++;
        end
        return made;
    endfunction

    // random mix of moves, clears and stray words
    function automatic void queue_random(input int quota);
        int made, pick;
        made = 0;
        while (made < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_word(2'($urandom_range(0, 3)), 10'($urandom), 8'($urandom),
                          1'($urandom), 10'($urandom), $urandom);
            end else if (pick < 20) begin
                push_word(CMD_CLEAR, 10'($urandom), 8'($urandom), 1'($urandom),
                          10'($urandom), $urandom);
                made++;
            end else begin
                made += queue_move();
            end
        end
    endfunction

    // register write over the config channel
    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DEFAULT_SPEED: cfg_default = val;
            CFG_MAX_SPEED:     cfg_max     = val;
            CFG_MIN_SPEED:     cfg_min     = val;
            CFG_DEAD_BAND:     cfg_band    = val[5:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic [9:0] dflt, input logic [9:0] mx,
                               input logic [9:0] mn, input logic [5:0] band);
        write_reg(CFG_DEFAULT_SPEED, dflt);
        write_reg(CFG_MAX_SPEED, mx);
        write_reg(CFG_MIN_SPEED, mn);
        write_reg(CFG_DEAD_BAND, {4'd0, band});
    endtask

    // wait until every word is sent and every reply is back
    task automatic settle();
        do @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: words and receiver stalls change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (!in_valid || in_fire) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_word <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check replies, then predict for the word taken at this edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_motion_reply got, want;
        in_fire <= in_valid && in_ready;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

        if (rst_n && out_valid && out_ready) begin
            got = '{speed_valid, speed_command, wheel_mode, phase, wait_state,
                    finished, stuck, refused, restore_valid, restore_position};
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: reply expected none actual %h", $time, got);
            end else begin
                want = expected_replies.pop_front();
                check_field("speed_valid", want.speed_valid, got.speed_valid);
                check_field("speed_command", want.speed_command, got.speed_command);
                check_field("wheel_mode", want.wheel_mode, got.wheel_mode);
                check_field("phase", want.phase, got.phase);
                check_field("wait_state", want.wait_state, got.wait_state);
                check_field("finished", want.finished, got.finished);
                check_field("stuck", want.stuck, got.stuck);
                check_field("refused", want.refused, got.refused);
                check_field("restore_valid", want.restore_valid, got.restore_valid);
                check_field("restore_position", want.restore_position,
                            got.restore_position);
            end
        end

        if (in_valid && in_ready)
            expected_replies.push_back(predict_motion(cur_word));
    end

    // watchdog on a stalled handshake
    initial begin
        while (idle_cycles < WATCHDOG_CYCLES) @(posedge clk);
        $display("servo_wrap_aware_positioner: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 60;

        // stray words while idle, unused command with all fields high
        push_word(CMD_SAMPLE, 10'd0, 8'd0, 1'b0, POS_TOP, 32'hFFFF_FFFF);
        push_word(2'd3, 10'd1023, 8'd255, 1'b1, 10'd1023, 32'hFFFF_FFFF);
        // start on target with the default speed: ends at once
        push_word(CMD_START, 10'd500, 8'd0, 1'b0, 10'd500, 32'd100);
        // full-speed start from the bottom, then through the top of the dead zone
        push_word(CMD_START, 10'd1023, 8'd255, 1'b1, POS_BOTTOM, 32'd0);
        for (int i = 1; i <= 4; i++)
            push_word(CMD_SAMPLE, 10'd0, 8'd0, 1'b0, POS_BOTTOM, 32'(i));
        for (int i = 5; i <= 8; i++)
            push_word(CMD_SAMPLE, 10'd0, 8'd0, 1'b0, POS_TOP, 32'(i));
        push_word(CMD_SAMPLE, 10'd0, 8'd0, 1'b0, 10'd1010, 32'd9);
        push_word(CMD_SAMPLE, 10'd0, 8'd0, 1'b0, 10'd1022, 32'd30);
        // slow start that stalls next to its start position
        push_word(CMD_START, 10'd200, 8'd1, 1'b0, 10'd600, 32'd1000);
        for (int i = 0; i < 4; i++)
            push_word(CMD_SAMPLE, 10'd0, 8'd0, 1'b0, 10'd600, 32'(1001 + i));
        push_word(CMD_SAMPLE, 10'd0, 8'd0, 1'b0, 10'd600, 32'd1600);
        // start refused while stuck, then cleared
        push_word(CMD_START, 10'd0, 8'd50, 1'b0, 10'd300, 32'd1700);
        push_word(CMD_CLEAR, 10'd0, 8'd0, 1'b0, 10'd0, 32'd0);
        // start, then restart near target into fine, then fine timeout over wrap
        push_word(CMD_START, 10'd100, 8'd20, 1'b1, 10'd900, 32'hFFFF_FF00);
        push_word(CMD_START, 10'd300, 8'd100, 1'b0, 10'd290, 32'hFFFF_FFF0);
        push_word(CMD_SAMPLE, 10'd0, 8'd0, 1'b0, 10'd320, 32'h0000_07E0);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 60;
                recv_idle_pct = 23;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: load_config(10'd1023, 10'd1023, 10'd1, 6'd0);
                1: load_config(10'd1, 10'd1, 10'd1023, 6'd63);
                3: load_config(DEFAULT_SPEED_RST, MAX_SPEED_RST, MIN_SPEED_RST,
                               DEAD_BAND_RST);
                default: load_config(10'($urandom_range(1, 1023)),
                                     10'($urandom_range(400, 1023)),
                                     10'($urandom_range(1, 200)),
                                     6'($urandom_range(0, 63)));
            endcase
            queue_random(RANDOM_QUOTA);
            settle();
        end

        if (mismatches == 0)
            $display("servo_wrap_aware_positioner: match");
        else
            $display("servo_wrap_aware_positioner: mismatch");
        $finish;
    end

endmodule
